// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// All assertions use clk and rst from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/v3a_pkg.sv =====
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, opcodes and helpers for the three-component Q16.16 vector unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_MAG   = 3'd4,
    OP_NORM  = 3'd5
  } opcode_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 48;
  localparam int STAGES     = SQRT_STEPS + DIV_STEPS;

  localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] scalar;
    logic               saturated;
    logic               zero_length;
  } out_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] sc;
    logic               sat;
    logic [63:0]        d;
    logic [33:0]        rem;
    logic [31:0]        root;
    logic [2:0][47:0]   num;
    logic [2:0]         neg;
    logic [2:0][31:0]   drem;
    logic [2:0][47:0]   quo;
  } norm_t;

  // Clip to Q16.16; bit 32 is the saturation flag.
  function automatic logic [32:0] clip_q(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > Q_MAX_W) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < Q_MIN_W) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/v3a_norm_pipe.sv =====
// ----------------------------------------------------------------------------
// v3a_norm_pipe
// Bit-per-stage square root and three parallel restoring dividers, then the
// final clip; other operations ride along unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module v3a_norm_pipe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire v3a_pkg::norm_t in_data,
  output logic               out_vld,
  output v3a_pkg::out_t      out_data
);
  import v3a_pkg::*;

  function automatic norm_t sqrt_step(input norm_t s);
    norm_t r;
    logic [35:0] t;
    logic [35:0] tr;
    r  = s;
    t  = {s.rem, s.d[63:62]};
    tr = {2'b00, s.root, 2'b01};
    if (t >= tr) begin
      r.rem  = 34'(t - tr);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    r.d = {s.d[61:0], 2'b00};
    return r;
  endfunction

  function automatic norm_t div_step(input norm_t s);
    norm_t r;
    logic [32:0] t;
    logic        qb;
    r = s;
    for (int c = 0; c < 3; c++) begin
      t = {s.drem[c], s.num[c][47]};
      qb = (t >= {1'b0, s.root});
      if (qb) begin
        r.drem[c] = 32'(t - {1'b0, s.root});
      end else begin
        r.drem[c] = t[31:0];
      end
      r.num[c] = {s.num[c][46:0], 1'b0};
      r.quo[c] = {s.quo[c][46:0], qb};
    end
    return r;
  endfunction

  function automatic out_t finish(input norm_t s);
    out_t        o;
    logic [47:0] q;
    logic [31:0] v;
    o = '0;
    case (s.op)
      OP_MAG: begin
        o.scalar    = s.root[31] ? 32'h7FFF_FFFF : s.root;
        o.saturated = s.root[31];
      end
      OP_NORM: begin
        if (s.root == 32'd0) begin
          o.zero_length = 1'b1;
        end else begin
          for (int c = 0; c < 3; c++) begin
            q = s.quo[c];
            if (s.neg[c]) begin
              if (q > 48'h0000_8000_0000) begin
                v = 32'h8000_0000;
                o.saturated = 1'b1;
              end else begin
                v = ~q[31:0] + 32'd1;
              end
            end else begin
              if (q > 48'h0000_7FFF_FFFF) begin
                v = 32'h7FFF_FFFF;
                o.saturated = 1'b1;
              end else begin
                v = q[31:0];
              end
            end
            case (c)
              0:       o.res_x = v;
              1:       o.res_y = v;
              default: o.res_z = v;
            endcase
          end
        end
      end
      default: begin
        o.res_x     = s.vx;
        o.res_y     = s.vy;
        o.res_z     = s.vz;
        o.scalar    = s.sc;
        o.saturated = s.sat;
      end
    endcase
    return o;
  endfunction

  norm_t st [1:STAGES];
  logic  vl [1:STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    norm_t cur;
    logic  cur_vld;
    norm_t nxt;

    if (k == 0) begin : g_head
      assign cur     = in_data;
      assign cur_vld = in_vld;
    end else begin : g_body
      assign cur     = st[k];
      assign cur_vld = vl[k];
    end

    if (k < SQRT_STEPS) begin : g_sqrt
      always_comb nxt = sqrt_step(cur);
    end else begin : g_div
      always_comb nxt = div_step(cur);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= cur_vld;
      end
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vl[STAGES];
    end
    if (en) begin
      out_data <= finish(st[STAGES]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component vector unit in signed Q16.16: add, subtract, dot, cross,
// magnitude and normalize, with saturation.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while req_stall is low, and every beat returns
// one result beat. The pipeline holds the 32-step square root followed
// by the 48-step quotient, each one bit per pipeline stage, plus the
// multiply, sum, clip and output stages. All operations share the same
// latency, so results leave in order. A skid register behind the output
// register holds one result while rsp_stall is high; req_stall rises only
// when that skid register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vector3_alu (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire v3a_pkg::in_t req,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output v3a_pkg::out_t     rsp
);
  import v3a_pkg::*;

  logic en;
  logic sk_vld;
  out_t sk;

  assign en        = !sk_vld;
  assign req_stall = sk_vld;

  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic               v1;
  in_t                r1;
  logic signed [63:0] p1 [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (req.opcode)
      OP_DOT: begin
        ma[0] = req.a_x; mb[0] = req.b_x;
        ma[1] = req.a_y; mb[1] = req.b_y;
        ma[2] = req.a_z; mb[2] = req.b_z;
      end
      OP_CROSS: begin
        ma[0] = req.a_y; mb[0] = req.b_z;
        ma[1] = req.a_z; mb[1] = req.b_y;
        ma[2] = req.a_z; mb[2] = req.b_x;
        ma[3] = req.a_x; mb[3] = req.b_z;
        ma[4] = req.a_x; mb[4] = req.b_y;
        ma[5] = req.a_y; mb[5] = req.b_x;
      end
      OP_MAG, OP_NORM: begin
        ma[0] = req.a_x; mb[0] = req.a_x;
        ma[1] = req.a_y; mb[1] = req.a_y;
        ma[2] = req.a_z; mb[2] = req.a_z;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
    if (en) begin
      r1 <= req;
      for (int i = 0; i < 6; i++) begin
        p1[i] <= ma[i] * mb[i];
      end
    end
  end

  logic signed [65:0] s3;
  logic signed [65:0] ex;
  logic signed [65:0] ey;
  logic signed [65:0] ez;
  logic [32:0]        cx;
  logic [32:0]        cy;
  logic [32:0]        cz;
  logic [63:0]        dsum;
  logic [31:0]        mx;
  logic [31:0]        my;
  logic [31:0]        mz;
  norm_t              n0;
  norm_t              n2;
  logic               v2;

  always_comb begin
    s3   = 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);
    dsum = $unsigned(p1[0]) + $unsigned(p1[1]) + $unsigned(p1[2]);
    mx   = r1.a_x[31] ? (~r1.a_x + 32'd1) : r1.a_x;
    my   = r1.a_y[31] ? (~r1.a_y + 32'd1) : r1.a_y;
    mz   = r1.a_z[31] ? (~r1.a_z + 32'd1) : r1.a_z;
    ex   = '0;
    ey   = '0;
    ez   = '0;
    case (r1.opcode)
      OP_ADD: begin
        ex = 66'(r1.a_x) + 66'(r1.b_x);
        ey = 66'(r1.a_y) + 66'(r1.b_y);
        ez = 66'(r1.a_z) + 66'(r1.b_z);
      end
      OP_SUB: begin
        ex = 66'(r1.a_x) - 66'(r1.b_x);
        ey = 66'(r1.a_y) - 66'(r1.b_y);
        ez = 66'(r1.a_z) - 66'(r1.b_z);
      end
      OP_DOT: begin
        ex = (s3 + 66'sd32768) >>> 16;
      end
      OP_CROSS: begin
        ex = (66'(p1[0]) - 66'(p1[1]) + 66'sd32768) >>> 16;
        ey = (66'(p1[2]) - 66'(p1[3]) + 66'sd32768) >>> 16;
        ez = (66'(p1[4]) - 66'(p1[5]) + 66'sd32768) >>> 16;
      end
      default: begin
      end
    endcase
    cx = clip_q(ex);
    cy = clip_q(ey);
    cz = clip_q(ez);

    n0        = '0;
    n0.op     = r1.opcode;
    n0.d      = dsum;
    n0.num[0] = {mx, 16'h0000};
    n0.num[1] = {my, 16'h0000};
    n0.num[2] = {mz, 16'h0000};
    n0.neg    = {r1.a_z[31], r1.a_y[31], r1.a_x[31]};
    case (r1.opcode)
      OP_ADD, OP_SUB, OP_CROSS: begin
        n0.vx  = cx[31:0];
        n0.vy  = cy[31:0];
        n0.vz  = cz[31:0];
        n0.sat = cx[32] | cy[32] | cz[32];
      end
      OP_DOT: begin
        n0.sc  = cx[31:0];
        n0.sat = cx[32];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      n2 <= n0;
    end
  end

  logic pv;
  out_t pd;

  v3a_norm_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v2),
    .in_data  (n2),
    .out_vld  (pv),
    .out_data (pd)
  );

  logic take;
  assign take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      sk_vld    <= 1'b0;
    end else if (sk_vld) begin
      if (take) begin
        sk_vld <= 1'b0;
      end
    end else if (pv) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        sk_vld <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_vld) begin
      if (take) begin
        rsp <= sk;
      end
    end else if (pv) begin
      if (!rsp_valid || take) begin
        rsp <= pd;
      end else begin
        sk <= pd;
      end
    end
  end

  `ASSERT_IMPL(a_skid_fill, $rose(sk_vld), $past(rsp_valid && rsp_stall))
  `ASSERT_IMPL(a_skid_behind_out, sk_vld, rsp_valid)
  `ASSERT_IMPL(a_zero_len_clean, rsp_valid && rsp.zero_length,
               !rsp.saturated && rsp.scalar == 32'sd0 && rsp.res_x == 32'sd0)

endmodule

`default_nettype wire

// ===== sim/vector3_alu_checker.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_checker
// Watches both channels of the vector unit, predicts every result beat from
// the request beats and compares field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector3_alu_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  v3a_pkg::in_t  req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  v3a_pkg::out_t rsp,
  output int            errors,
  output int            pending,
  output int            seen
);
  import v3a_pkg::*;

  out_t results_due[$];

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // round a Q32.32 sum to Q16.16, ties up
  function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
    return (v + 128'sd32768) >>> 16;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic out_t vector_result(input in_t q);
    out_t o;
    logic signed [127:0] a[3], b[3], v;
    logic [63:0] d, m;
    logic sat;
    o = '0;
    sat = 1'b0;
    a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
    b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
    case (q.opcode)
      OP_ADD, OP_SUB: begin
        o.res_x = clamp(q.opcode == OP_ADD ? a[0] + b[0] : a[0] - b[0], sat);
        o.res_y = clamp(q.opcode == OP_ADD ? a[1] + b[1] : a[1] - b[1], sat);
        o.res_z = clamp(q.opcode == OP_ADD ? a[2] + b[2] : a[2] - b[2], sat);
      end
      OP_DOT: o.scalar = clamp(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), sat);
      OP_CROSS: begin
        o.res_x = clamp(round_q(a[1] * b[2] - a[2] * b[1]), sat);
        o.res_y = clamp(round_q(a[2] * b[0] - a[0] * b[2]), sat);
        o.res_z = clamp(round_q(a[0] * b[1] - a[1] * b[0]), sat);
      end
      OP_MAG, OP_NORM: begin
        v = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        d = v[63:0];
        m = root64(d);
        if (q.opcode == OP_MAG) begin
          o.scalar = clamp({64'd0, m}, sat);
        end else if (m == 0) begin
          o.zero_length = 1'b1;
        end else begin
          o.res_x = clamp((a[0] * 65536) / $signed({64'd0, m}), sat);
          o.res_y = clamp((a[1] * 65536) / $signed({64'd0, m}), sat);
          o.res_z = clamp((a[2] * 65536) / $signed({64'd0, m}), sat);
        end
      end
      default: ;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    seen = 0;
  end
  assign pending = results_due.size();

  always @(posedge clk) begin
    out_t e;
    if (!rst && req_valid && !req_stall) results_due.push_back(vector_result(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        e = results_due.pop_front();
        if (rsp.res_x !== e.res_x) report_mismatch("res_x", rsp.res_x, e.res_x);
        if (rsp.res_y !== e.res_y) report_mismatch("res_y", rsp.res_y, e.res_y);
        if (rsp.res_z !== e.res_z) report_mismatch("res_z", rsp.res_z, e.res_z);
        if (rsp.scalar !== e.scalar) report_mismatch("scalar", rsp.scalar, e.scalar);
        if (rsp.saturated !== e.saturated)
          report_mismatch("saturated", rsp.saturated, e.saturated);
        if (rsp.zero_length !== e.zero_length)
          report_mismatch("zero_length", rsp.zero_length, e.zero_length);
      end
    end
  end
endmodule

// ===== sim/tb_vector3_alu.sv =====
// ----------------------------------------------------------------------------
// tb_vector3_alu
// Directed and random vector operations through the unit under sender gaps
// and receiver stalls; a checker module predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vector3_alu;
  import v3a_pkg::*;

  localparam int LATENCY = 84;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;
  int errors, pending, seen;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  int quiet = 0;
  bit done = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vector3_alu uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  vector3_alu_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .errors(errors), .pending(pending), .seen(seen)
  );

  // receiver stall generator
  always @(negedge clk) begin
    if (hold_off > 0) begin
      rsp_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || done) begin
      quiet <= 0;
    end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("watchdog expired");
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [31:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{opcode: op, a_x: ax, a_y: ay, a_z: az, b_x: bx, b_y: by, b_z: bz};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      send_beat(op, pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value());
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h1, 32'hFFFF_FFFF, 32'h2);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678, 32'h1, 32'h0, 32'h0);
    send_beat(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h1, 32'hFFFF_FFFF, 32'h5);
    send_beat(OP_DOT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              32'h0004_0000, 32'h0005_0000, 32'h0006_0000);
    send_beat(OP_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(OP_DOT, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
    send_beat(OP_DOT, 32'h0000_8000, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    send_beat(OP_DOT, 32'hFFFF_8000, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    send_beat(OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_beat(OP_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_beat(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_NORM, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2);
    send_beat(OP_NORM, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_NORM, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_beat(OP_NORM, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(3'd6, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6);
    send_beat(3'd7, 32'hFFFF_FFFF, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6);
    drain();

    send_random(200);
    send_idle = 60;
    send_random(150);
    send_idle = 0;
    recv_idle = 60;
    send_random(150);
    send_idle = 12;
    recv_idle = 12;
    send_random(150);
    drain();

    // long receiver hold while the sender keeps going
    send_idle = 0;
    recv_idle = 0;
    @(negedge clk);
    hold_off <= 300;
    send_random(100);
    drain();

    done = 1;
    repeat (LATENCY + 20) @(posedge clk);
    $display("Covered %0d result beats: all opcodes, field extremes, saturation,", seen);
    $display("zero-length normalize, unused opcodes, sender gaps and receiver stalls.");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
